[sv/scroll_acceleration_macros.svh]
// Assertion helpers for the scroll acceleration block.
`ifndef SCROLL_ACCELERATION_MACROS_SVH
`define SCROLL_ACCELERATION_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("scroll_acceleration: check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("scroll_acceleration: check failed");

`endif

[sv/sa_pkg.sv]
package sa_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;

  // Fixed-point one in Q.16.
  localparam logic [31:0] ONE_Q16 = 32'd65536;

  // Gain saturation limit, 2^39.
  localparam logic signed [40:0] M_POS = 41'sd549755813888;
  localparam logic signed [40:0] M_NEG = -41'sd549755813888;

  localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] OUT_MIN = 24'sh800000;

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_CLEAR_MS   = 3'd0,
    REG_EVENT_MS   = 3'd1,
    REG_COEFF_SQ   = 3'd2,
    REG_COEFF_LIN  = 3'd3,
    REG_COEFF_CON  = 3'd4,
    REG_MIN_GAIN   = 3'd5,
    REG_RATE_SCALE = 3'd6,
    REG_NONE       = 3'd7
  } reg_idx_t;

  localparam logic [15:0] RST_CLEAR_MS   = 16'd200;
  localparam logic [15:0] RST_EVENT_MS   = 16'd20;
  localparam logic [23:0] RST_COEFF_SQ   = 24'd65;
  localparam logic [23:0] RST_COEFF_LIN  = 24'd6554;
  localparam logic [23:0] RST_COEFF_CON  = 24'd131072;
  localparam logic [23:0] RST_MIN_GAIN   = 24'd65536;
  localparam logic [15:0] RST_RATE_SCALE = 16'd4096;

  typedef struct packed {
    logic [15:0] clear_ms;
    logic [15:0] event_ms;
    logic [23:0] coeff_square;
    logic [23:0] coeff_linear;
    logic [23:0] coeff_constant;
    logic [23:0] min_gain;
    logic [15:0] rate_scale;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_RD, ST_ACC,
    ST_DXS, ST_DXW, ST_DYS, ST_DYW, ST_DTS, ST_DTW,
    ST_T, ST_SQ, ST_B, ST_A1, ST_A2, ST_M0, ST_M,
    ST_GX, ST_GY, ST_OX, ST_OY, ST_DONE, ST_ZERO
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_T, OP_SQ, OP_B, OP_A1, OP_A2, OP_M0, OP_M,
    OP_GX, OP_GY, OP_OX, OP_OY
  } op_t;

  typedef enum logic [1:0] {
    DS_X, DS_Y, DS_T
  } dsel_t;

  typedef struct packed {
    logic  in_ready;
    logic  store;
    logic  walk_init;
    logic  rd;
    logic  acc;
    logic  div_start;
    logic  div_cap;
    dsel_t dsel;
    op_t   op;
    logic  out_load;
    logic  out_zero;
  } cmd_t;

  typedef struct packed {
    logic ring_empty;
    logic walk_last;
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

[sv/sa_ifs.sv]
interface sa_evt_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic        [31:0] time_ms;
  logic               force_clear;

  modport source (output valid, delta_x, delta_y, time_ms, force_clear, input ready);
  modport sink (input valid, delta_x, delta_y, time_ms, force_clear, output ready);
endinterface

interface sa_res_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] scroll_x;
  logic signed [23:0] scroll_y;

  modport source (output valid, scroll_x, scroll_y, input ready);
  modport sink (input valid, scroll_x, scroll_y, output ready);
endinterface

[sv/sa_div.sv]
// Restoring divider, one quotient bit per cycle.
module sa_div #(
  parameter int DVW = 33,
  parameter int NW  = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [NW-1:0]  divisor,
  output logic           busy,
  output logic [DVW-1:0] quotient
);

  localparam int CNTW = $clog2(DVW + 1);

  logic [NW-1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic [NW:0]     trial;
  logic            fits;

  assign trial = {rem, quotient[DVW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(DVW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= NW'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[NW-1:0];
      end
      quotient <= {quotient[DVW-2:0], fits};
    end
  end

endmodule

[sv/sa_ctrl.sv]
module sa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  sa_pkg::sts_t  sts,
  output sa_pkg::cmd_t  cmd
);

  sa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sa_pkg::ST_IDLE:  if (in_valid) state_next = sa_pkg::ST_CHECK;
      sa_pkg::ST_CHECK: state_next = sts.ring_empty ? sa_pkg::ST_ZERO : sa_pkg::ST_RD;
      sa_pkg::ST_RD:    state_next = sa_pkg::ST_ACC;
      sa_pkg::ST_ACC:   state_next = sts.walk_last ? sa_pkg::ST_DXS : sa_pkg::ST_RD;
      sa_pkg::ST_DXS:   state_next = sa_pkg::ST_DXW;
      sa_pkg::ST_DXW:   if (!sts.div_busy) state_next = sa_pkg::ST_DYS;
      sa_pkg::ST_DYS:   state_next = sa_pkg::ST_DYW;
      sa_pkg::ST_DYW:   if (!sts.div_busy) state_next = sa_pkg::ST_DTS;
      sa_pkg::ST_DTS:   state_next = sa_pkg::ST_DTW;
      sa_pkg::ST_DTW:   if (!sts.div_busy) state_next = sa_pkg::ST_T;
      sa_pkg::ST_T:     state_next = sa_pkg::ST_SQ;
      sa_pkg::ST_SQ:    state_next = sa_pkg::ST_B;
      sa_pkg::ST_B:     state_next = sa_pkg::ST_A1;
      sa_pkg::ST_A1:    state_next = sa_pkg::ST_A2;
      sa_pkg::ST_A2:    state_next = sa_pkg::ST_M0;
      sa_pkg::ST_M0:    state_next = sa_pkg::ST_M;
      sa_pkg::ST_M:     state_next = sa_pkg::ST_GX;
      sa_pkg::ST_GX:    state_next = sa_pkg::ST_GY;
      sa_pkg::ST_GY:    state_next = sa_pkg::ST_OX;
      sa_pkg::ST_OX:    state_next = sa_pkg::ST_OY;
      sa_pkg::ST_OY:    state_next = sa_pkg::ST_DONE;
      sa_pkg::ST_DONE:  if (!sts.out_busy) state_next = sa_pkg::ST_IDLE;
      sa_pkg::ST_ZERO:  if (!sts.out_busy) state_next = sa_pkg::ST_IDLE;
      default:          state_next = sa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.dsel = sa_pkg::DS_X;
    cmd.op   = sa_pkg::OP_NONE;
    unique case (state)
      sa_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.store    = in_valid;
      end
      sa_pkg::ST_CHECK: cmd.walk_init = !sts.ring_empty;
      sa_pkg::ST_RD:    cmd.rd = 1'b1;
      sa_pkg::ST_ACC:   cmd.acc = 1'b1;
      sa_pkg::ST_DXS:   cmd.div_start = 1'b1;
      sa_pkg::ST_DXW:   cmd.div_cap = !sts.div_busy;
      sa_pkg::ST_DYS: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = sa_pkg::DS_Y;
      end
      sa_pkg::ST_DYW: begin
        cmd.div_cap = !sts.div_busy;
        cmd.dsel    = sa_pkg::DS_Y;
      end
      sa_pkg::ST_DTS: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = sa_pkg::DS_T;
      end
      sa_pkg::ST_DTW: begin
        cmd.div_cap = !sts.div_busy;
        cmd.dsel    = sa_pkg::DS_T;
      end
      sa_pkg::ST_T:     cmd.op = sa_pkg::OP_T;
      sa_pkg::ST_SQ:    cmd.op = sa_pkg::OP_SQ;
      sa_pkg::ST_B:     cmd.op = sa_pkg::OP_B;
      sa_pkg::ST_A1:    cmd.op = sa_pkg::OP_A1;
      sa_pkg::ST_A2:    cmd.op = sa_pkg::OP_A2;
      sa_pkg::ST_M0:    cmd.op = sa_pkg::OP_M0;
      sa_pkg::ST_M:     cmd.op = sa_pkg::OP_M;
      sa_pkg::ST_GX:    cmd.op = sa_pkg::OP_GX;
      sa_pkg::ST_GY:    cmd.op = sa_pkg::OP_GY;
      sa_pkg::ST_OX:    cmd.op = sa_pkg::OP_OX;
      sa_pkg::ST_OY:    cmd.op = sa_pkg::OP_OY;
      sa_pkg::ST_DONE:  cmd.out_load = !sts.out_busy;
      sa_pkg::ST_ZERO: begin
        cmd.out_load = !sts.out_busy;
        cmd.out_zero = 1'b1;
      end
      default: cmd.op = sa_pkg::OP_NONE;
    endcase
  end

endmodule

[sv/sa_dp.sv]
module sa_dp #(
  parameter int HISTORY_DEPTH = sa_pkg::HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sa_pkg::cfg_t       cfg,
  input  sa_pkg::cmd_t       cmd,
  output sa_pkg::sts_t       sts,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  input  logic        [31:0] time_ms,
  input  logic               force_clear,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [23:0] scroll_x,
  output logic signed [23:0] scroll_y
);

  localparam int HW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUMW = 16 + HW;
  localparam int DVW  = (SUMW + 8 > 33) ? SUMW + 8 : 33;

  localparam logic signed [47:0] OUT_MAX_EXT = 48'(sa_pkg::OUT_MAX);
  localparam logic signed [47:0] OUT_MIN_EXT = 48'(sa_pkg::OUT_MIN);

  logic signed [15:0] mem_dx  [HISTORY_DEPTH];
  logic signed [15:0] mem_dy  [HISTORY_DEPTH];
  logic        [15:0] mem_gap [HISTORY_DEPTH];

  logic [HW-1:0]      head;
  logic [CW-1:0]      count;
  logic [31:0]        last_time;
  logic signed [15:0] dx_new, dy_new;

  // Ring write side.
  logic        nonzero, clr;
  logic [31:0] gap_eff;
  logic [15:0] gap_st;
  logic [CW-1:0] cnt_base;

  assign nonzero  = (delta_x != '0) || (delta_y != '0);
  assign gap_eff  = (count == '0) ? 32'd0 : time_ms - last_time;
  assign clr      = (gap_eff >= {16'd0, cfg.clear_ms}) || force_clear;
  assign gap_st   = clr ? cfg.clear_ms : gap_eff[15:0];
  assign cnt_base = clr ? '0 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      last_time <= '0;
    end else if (cmd.store && nonzero) begin
      head      <= (head == HW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;
      count     <= (cnt_base == CW'(HISTORY_DEPTH)) ? cnt_base : cnt_base + 1'b1;
      last_time <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && nonzero) begin
      mem_dx[head]  <= delta_x;
      mem_dy[head]  <= delta_y;
      mem_gap[head] <= gap_st;
      dx_new        <= delta_x;
      dy_new        <= delta_y;
    end
  end

  // Walk over the ring, newest first.
  logic [HW-1:0]      idx;
  logic [CW-1:0]      k, n;
  logic [SUMW-1:0]    sx, sy;
  logic [16:0]        st;
  logic signed [15:0] rd_dx, rd_dy;
  logic [15:0]        rd_gap;
  logic               stop_gap, last_entry;
  logic [16:0]        st_new;
  logic [15:0]        abs_x, abs_y;

  assign stop_gap   = (rd_gap == '0) || (rd_gap >= cfg.event_ms);
  assign st_new     = st + {1'b0, stop_gap ? cfg.event_ms : rd_gap};
  assign abs_x      = rd_dx[15] ? 16'(-rd_dx) : 16'(rd_dx);
  assign abs_y      = rd_dy[15] ? 16'(-rd_dy) : 16'(rd_dy);
  assign last_entry = stop_gap || (st_new >= {1'b0, cfg.clear_ms}) || (k + 1'b1 == count);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      idx <= (head == '0) ? HW'(HISTORY_DEPTH - 1) : head - 1'b1;
      k   <= '0;
      n   <= '0;
      sx  <= '0;
      sy  <= '0;
      st  <= '0;
    end else if (cmd.rd) begin
      rd_dx  <= mem_dx[idx];
      rd_dy  <= mem_dy[idx];
      rd_gap <= mem_gap[idx];
    end else if (cmd.acc) begin
      n   <= n + 1'b1;
      k   <= k + 1'b1;
      st  <= st_new;
      idx <= (idx == '0) ? HW'(HISTORY_DEPTH - 1) : idx - 1'b1;
      if (!stop_gap) begin
        sx <= sx + SUMW'(abs_x);
        sy <= sy + SUMW'(abs_y);
      end
    end
  end

  // Averages through the shared divider.
  logic [DVW-1:0] dividend, quotient;
  logic           div_busy;
  logic [23:0]    avg_x, avg_y;
  logic [32:0]    avg_t;

  always_comb begin
    case (cmd.dsel)
      sa_pkg::DS_X: dividend = DVW'({sx, 8'd0});
      sa_pkg::DS_Y: dividend = DVW'({sy, 8'd0});
      default:      dividend = DVW'({st, 16'd0});
    endcase
  end

  sa_div #(
    .DVW (DVW),
    .NW  (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (n),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      case (cmd.dsel)
        sa_pkg::DS_X: avg_x <= quotient[23:0];
        sa_pkg::DS_Y: avg_y <= quotient[23:0];
        default:      avg_t <= quotient[32:0];
      endcase
    end
  end

  // Gain curve, at most one multiply per step.
  logic [31:0]        t;
  logic [47:0]        sq;
  logic [39:0]        tb;
  logic [55:0]        ta_hi;
  logic [23:0]        ta_lo;
  logic signed [57:0] m0;
  logic signed [40:0] m;
  logic [46:0]        gx, gy;
  logic signed [23:0] ox, oy;

  logic [48:0]        p_t;
  logic [36:0]        t_raw;
  logic [36:0]        t_cap;
  logic [31:0]        et_q;
  logic signed [74:0] p_m;
  logic signed [62:0] q_m;
  logic signed [65:0] p_g;
  logic signed [49:0] q_g;
  logic [23:0]        avg_sel;
  logic [46:0]        g_sel;
  logic signed [15:0] d_sel;
  logic signed [63:0] p_o;
  logic signed [47:0] q_o;
  logic signed [23:0] o_sat;

  assign p_t   = avg_t * cfg.rate_scale;
  assign t_raw = p_t[48:12];
  assign et_q  = {cfg.event_ms, 16'd0};
  // The upper clamp comes first, so a zero event threshold still ends at 1.0.
  assign t_cap = (t_raw > 37'(et_q)) ? 37'(et_q) : t_raw;

  assign p_m = m0 * $signed({1'b0, cfg.rate_scale});
  assign q_m = p_m[74:12];

  assign avg_sel = (cmd.op == sa_pkg::OP_GX) ? avg_x : avg_y;
  assign p_g     = m * $signed({1'b0, avg_sel});
  assign q_g     = p_g[65:16];

  assign g_sel = (cmd.op == sa_pkg::OP_OX) ? gx : gy;
  assign d_sel = (cmd.op == sa_pkg::OP_OX) ? dx_new : dy_new;
  assign p_o   = d_sel * $signed({1'b0, g_sel});
  assign q_o   = p_o[63:16];

  always_comb begin
    if (q_o > OUT_MAX_EXT) begin
      o_sat = sa_pkg::OUT_MAX;
    end else if (q_o < OUT_MIN_EXT) begin
      o_sat = sa_pkg::OUT_MIN;
    end else begin
      o_sat = q_o[23:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      sa_pkg::OP_T: begin
        if (t_cap < 37'(sa_pkg::ONE_Q16)) begin
          t <= sa_pkg::ONE_Q16;
        end else begin
          t <= t_cap[31:0];
        end
      end
      sa_pkg::OP_SQ: sq <= 48'((64'(t) * 64'(t)) >> 16);
      sa_pkg::OP_B:  tb <= 40'((56'(cfg.coeff_linear) * 56'(t)) >> 16);
      sa_pkg::OP_A1: ta_hi <= 56'(cfg.coeff_square) * 56'(sq[47:16]);
      sa_pkg::OP_A2: ta_lo <= 24'((40'(cfg.coeff_square) * 40'(sq[15:0])) >> 16);
      sa_pkg::OP_M0: begin
        m0 <= $signed({2'b0, ta_hi}) + $signed(58'(ta_lo)) - $signed(58'(tb))
            + $signed(58'(cfg.coeff_constant));
      end
      sa_pkg::OP_M: begin
        if (q_m > 63'(sa_pkg::M_POS)) begin
          m <= sa_pkg::M_POS;
        end else if (q_m < 63'(sa_pkg::M_NEG)) begin
          m <= sa_pkg::M_NEG;
        end else begin
          m <= q_m[40:0];
        end
      end
      sa_pkg::OP_GX: gx <= (q_g < $signed(50'(cfg.min_gain))) ? 47'(cfg.min_gain) : q_g[46:0];
      sa_pkg::OP_GY: gy <= (q_g < $signed(50'(cfg.min_gain))) ? 47'(cfg.min_gain) : q_g[46:0];
      sa_pkg::OP_OX: ox <= o_sat;
      sa_pkg::OP_OY: oy <= o_sat;
      default: ;
    endcase
  end

  // Output register; the next item can be taken while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      scroll_x <= cmd.out_zero ? '0 : ox;
      scroll_y <= cmd.out_zero ? '0 : oy;
    end
  end

  assign sts.ring_empty = (count == '0);
  assign sts.walk_last  = last_entry;
  assign sts.div_busy   = div_busy;
  assign sts.out_busy   = out_valid && !out_ready;

endmodule

[sv/scroll_acceleration.sv]
// Scroll acceleration: speed-dependent gain for scroll events.
// The evt channel takes one event (delta_x, delta_y, time_ms, force_clear);
// the res channel gives exactly one item (scroll_x, scroll_y) per event.
// Both channels use valid/ready; an item moves when both are high.
// Registers are written over the APB port at byte address 4*index and
// should only be changed while no event is in flight.
// One event at a time: evt.ready is high only while the controller idles.
// The time from acceptance to res.valid grows with n (1..HISTORY_DEPTH), the
// number of ring entries averaged, and with DVW (33 for the default depth),
// the width of the bit-serial divider that forms the three averages.
// An empty ring answers with zeros.
// The result sits in an output register, so the next event can be taken
// while the receiver stalls; the controller only waits if a second result
// is ready before the first one was taken.
// Reset (rst, synchronous) empties the ring, clears the last timestamp and
// restores the register defaults; history contents are not cleared.
`include "scroll_acceleration_macros.svh"

module scroll_acceleration #(
  parameter int HISTORY_DEPTH = sa_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  sa_evt_if.sink                    evt,
  sa_res_if.source                  res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  sa_pkg::cfg_t     cfg;
  sa_pkg::cmd_t     cmd;
  sa_pkg::sts_t     sts;
  sa_pkg::reg_idx_t reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = sa_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clear_ms       <= sa_pkg::RST_CLEAR_MS;
      cfg.event_ms       <= sa_pkg::RST_EVENT_MS;
      cfg.coeff_square   <= sa_pkg::RST_COEFF_SQ;
      cfg.coeff_linear   <= sa_pkg::RST_COEFF_LIN;
      cfg.coeff_constant <= sa_pkg::RST_COEFF_CON;
      cfg.min_gain       <= sa_pkg::RST_MIN_GAIN;
      cfg.rate_scale     <= sa_pkg::RST_RATE_SCALE;
    end else if (wr_en) begin
      unique case (reg_idx)
        sa_pkg::REG_CLEAR_MS:   cfg.clear_ms       <= pwdata[15:0];
        sa_pkg::REG_EVENT_MS:   cfg.event_ms       <= pwdata[15:0];
        sa_pkg::REG_COEFF_SQ:   cfg.coeff_square   <= pwdata[23:0];
        sa_pkg::REG_COEFF_LIN:  cfg.coeff_linear   <= pwdata[23:0];
        sa_pkg::REG_COEFF_CON:  cfg.coeff_constant <= pwdata[23:0];
        sa_pkg::REG_MIN_GAIN:   cfg.min_gain       <= pwdata[23:0];
        sa_pkg::REG_RATE_SCALE: cfg.rate_scale     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sa_pkg::REG_CLEAR_MS:   prdata = {16'd0, cfg.clear_ms};
      sa_pkg::REG_EVENT_MS:   prdata = {16'd0, cfg.event_ms};
      sa_pkg::REG_COEFF_SQ:   prdata = {8'd0, cfg.coeff_square};
      sa_pkg::REG_COEFF_LIN:  prdata = {8'd0, cfg.coeff_linear};
      sa_pkg::REG_COEFF_CON:  prdata = {8'd0, cfg.coeff_constant};
      sa_pkg::REG_MIN_GAIN:   prdata = {8'd0, cfg.min_gain};
      sa_pkg::REG_RATE_SCALE: prdata = {16'd0, cfg.rate_scale};
      default:                prdata = 32'd0;
    endcase
  end

  sa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (evt.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign evt.ready = cmd.in_ready;

  sa_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .delta_x     (evt.delta_x),
    .delta_y     (evt.delta_y),
    .time_ms     (evt.time_ms),
    .force_clear (evt.force_clear),
    .out_ready   (res.ready),
    .out_valid   (res.valid),
    .scroll_x    (res.scroll_x),
    .scroll_y    (res.scroll_y)
  );

  // Only one event is in flight at a time.
  `SA_ASSERT_NXT(a_one_in_flight, clk, rst, evt.valid && evt.ready, !evt.ready)
  // A result is never loaded over one that the receiver has not taken.
  `SA_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !sts.out_busy)
  // A loaded result shows up on the output channel.
  `SA_ASSERT_NXT(a_load_shows, clk, rst, cmd.out_load, res.valid)

endmodule
